### hdl/tash_pkg.sv
// Shared types and codes for the two-axis stepper homing sequencer.
package tash_pkg;

  // Command codes carried in the input tuser field
  localparam logic [1:0] CMD_MOVE = 2'd1;
  localparam logic [1:0] CMD_HOME = 2'd2;

  // Per-axis direction request codes
  localparam logic [1:0] DIR_FWD = 2'd1;
  localparam logic [1:0] DIR_BWD = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_AREA_SIDE = 2'd0;
  localparam logic [1:0] REG_BACKOFF_X = 2'd1;
  localparam logic [1:0] REG_BACKOFF_Y = 2'd2;

  // Field widths fixed by the interface
  localparam int unsigned COIL_W    = 4;
  localparam int unsigned AREA_W    = 15;
  localparam int unsigned BACKOFF_W = 16;
  localparam int unsigned OUT_POS_W = 16;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 48;

  // Register reset values
  localparam logic [AREA_W-1:0]    AREA_SIDE_RST = 15'd1000;
  localparam logic [BACKOFF_W-1:0] BACKOFF_X_RST = 16'd600;
  localparam logic [BACKOFF_W-1:0] BACKOFF_Y_RST = 16'd100;

  // Homing sequence phases
  typedef enum logic [2:0] {
    HOME_IDLE   = 3'd0,
    HOME_SEEK_X = 3'd1,
    HOME_BACK_X = 3'd2,
    HOME_SEEK_Y = 3'd3,
    HOME_BACK_Y = 3'd4
  } home_phase_t;

endpackage

### hdl/two_axis_stepper_homing_top.sv
// Two-axis wave-drive stepper sequencer with a limit-switch homing sequence.
//
// Usage:
//   in_*  : one transfer per step tick. tuser holds the command (idle, move,
//           home); tdata holds both direction requests and the limit level.
//   out_* : one transfer per tick with the coil patterns, positions, the
//           stepped flag and the homing flag as they stand after the tick.
//   cfg_* : register writes (area side, X and Y back-off counts), always
//           ready; write only while no tick is in flight.
// A tick shows on out_* right after the edge that accepts it. One tick is
// accepted every cycle while the output register is empty or being taken;
// the step decision, position increment and limit compare of both axes
// are done in the cycle of the transfer, straight into the axis state and the
// output register.
// When the receiver stalls, the output register holds its result and in_tready
// drops until that result is taken; a tick may enter in the same cycle that
// the waiting result leaves.
// Reset clears positions, coil patterns and the homing sequence, reloads the
// registers with their defaults and empties the output register.
module two_axis_stepper_homing_top #(
  parameter int unsigned PHASES    = 4,
  parameter int unsigned POS_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // tdata: dir_x[1:0], dir_y[3:2], limit_level[4], zero fill [7:5]
  input  logic [tash_pkg::IN_DATA_W-1:0]      in_tdata,
  // tuser: cmd[1:0]
  input  logic [1:0]                          in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata: coils_x[3:0], coils_y[7:4], stepped[8], pos_x[24:9],
  //        pos_y[40:25], homing[41], zero fill [47:42]
  output logic [tash_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [tash_pkg::BACKOFF_W-1:0]      cfg_data
);

  localparam int unsigned PH_W = $clog2(PHASES);
  localparam int unsigned CMP_W = POS_WIDTH + 16;
  localparam longint HALF = longint'(1) << (POS_WIDTH - 1);
  // Phase reached after wrapping to the largest or smallest position
  localparam logic [PH_W-1:0] PH_AT_MAX = PH_W'((HALF - 1) % PHASES);
  localparam logic [PH_W-1:0] PH_AT_MIN = PH_W'((PHASES - (HALF % PHASES)) % PHASES);
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(PHASES - 1);
  localparam logic [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
  localparam int unsigned OUT_DATA_W_POS_FILL = 5;

  // Configuration registers
  logic [tash_pkg::AREA_W-1:0]    area_side_r;
  logic [tash_pkg::BACKOFF_W-1:0] backoff_x_r;
  logic [tash_pkg::BACKOFF_W-1:0] backoff_y_r;

  // Axis state, index 0 is X and 1 is Y
  logic [POS_WIDTH-1:0]        pos_r     [2];
  logic [POS_WIDTH-1:0]        pos_nxt   [2];
  logic [PH_W-1:0]             ph_r      [2];
  logic [PH_W-1:0]             ph_nxt    [2];
  logic [PH_W-1:0]             ph_step   [2];
  logic [tash_pkg::COIL_W-1:0] coils_r   [2];
  logic [tash_pkg::COIL_W-1:0] coils_nxt [2];
  logic [1:0]                  step_fwd;
  logic [1:0]                  step_bwd;
  logic [1:0]                  zero_pos;
  logic [1:0]                  at_top;
  logic [1:0]                  above_zero;
  logic [1:0]                  dir [2];

  tash_pkg::home_phase_t       home_r, home_nxt;
  logic [tash_pkg::BACKOFF_W-1:0] cnt_r, cnt_nxt;

  logic                        out_valid_r;
  logic [tash_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_DATA_W_POS_FILL:0] unused_fill;

  logic        in_accept;
  logic [1:0]  cmd;
  logic        limit_level;
  logic        stepped;

  assign cfg_ready   = 1'b1;
  assign in_tready   = !out_valid_r || out_tready;
  assign in_accept   = in_tvalid && in_tready;
  assign cmd         = in_tuser;
  assign dir[0]      = in_tdata[1:0];
  assign dir[1]      = in_tdata[3:2];
  assign limit_level = in_tdata[4];
  assign unused_fill = '0;

  // Limit compares, signed position against the unsigned area side
  always_comb begin
    logic signed [CMP_W-1:0] pos_ext;
    logic signed [CMP_W-1:0] area_ext;
    for (int a = 0; a < 2; a++) begin
      pos_ext       = {{16{pos_r[a][POS_WIDTH-1]}}, pos_r[a]};
      area_ext      = {{(CMP_W - tash_pkg::AREA_W){1'b0}}, area_side_r};
      at_top[a]     = pos_ext >= area_ext;
      above_zero[a] = pos_ext > CMP_W'(0);
    end
  end

  // Next homing phase and back-off count
  always_comb begin
    home_nxt = home_r;
    cnt_nxt  = cnt_r;
    unique case (home_r)
      tash_pkg::HOME_IDLE: begin
        if (cmd == tash_pkg::CMD_HOME) home_nxt = tash_pkg::HOME_SEEK_X;
      end
      tash_pkg::HOME_SEEK_X: begin
        if (limit_level) begin
          cnt_nxt  = backoff_x_r;
          home_nxt = (backoff_x_r == '0) ? tash_pkg::HOME_SEEK_Y : tash_pkg::HOME_BACK_X;
        end
      end
      tash_pkg::HOME_BACK_X: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 16'd1) home_nxt = tash_pkg::HOME_SEEK_Y;
      end
      tash_pkg::HOME_SEEK_Y: begin
        if (limit_level) begin
          cnt_nxt  = backoff_y_r;
          home_nxt = (backoff_y_r == '0) ? tash_pkg::HOME_IDLE : tash_pkg::HOME_BACK_Y;
        end
      end
      tash_pkg::HOME_BACK_Y: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 16'd1) home_nxt = tash_pkg::HOME_IDLE;
      end
      default: home_nxt = tash_pkg::HOME_IDLE;
    endcase
  end

  // Step and zeroing controls per axis
  always_comb begin
    step_fwd = '0;
    step_bwd = '0;
    zero_pos = '0;
    unique case (home_r)
      tash_pkg::HOME_IDLE: begin
        if (cmd == tash_pkg::CMD_MOVE) begin
          for (int a = 0; a < 2; a++) begin
            step_fwd[a] = (dir[a] == tash_pkg::DIR_FWD) && !at_top[a];
            step_bwd[a] = (dir[a] == tash_pkg::DIR_BWD) && above_zero[a];
          end
        end
      end
      tash_pkg::HOME_SEEK_X: begin
        step_bwd[0] = !limit_level;
        zero_pos[0] = limit_level && (backoff_x_r == '0);
      end
      tash_pkg::HOME_BACK_X: begin
        step_fwd[0] = 1'b1;
        zero_pos[0] = cnt_r == 16'd1;
      end
      tash_pkg::HOME_SEEK_Y: begin
        step_bwd[1] = !limit_level;
        zero_pos[1] = limit_level && (backoff_y_r == '0);
      end
      tash_pkg::HOME_BACK_Y: begin
        step_fwd[1] = 1'b1;
        zero_pos[1] = cnt_r == 16'd1;
      end
      default: ;
    endcase
  end

  assign stepped = |{step_fwd, step_bwd};

  // Position, phase and coil pattern update per axis
  always_comb begin
    logic [tash_pkg::COIL_W-1:0] ph_ext;
    for (int a = 0; a < 2; a++) begin
      if (step_fwd[a]) begin
        if (pos_r[a] == POS_MAX) ph_step[a] = PH_AT_MIN;
        else if (ph_r[a] == PH_LAST) ph_step[a] = '0;
        else ph_step[a] = ph_r[a] + 1'b1;
      end else begin
        if (pos_r[a] == POS_MIN) ph_step[a] = PH_AT_MAX;
        else if (ph_r[a] == '0) ph_step[a] = PH_LAST;
        else ph_step[a] = ph_r[a] - 1'b1;
      end
      ph_ext = tash_pkg::COIL_W'(ph_step[a]);

      priority if (zero_pos[a]) pos_nxt[a] = '0;
      else if (step_fwd[a]) pos_nxt[a] = pos_r[a] + 1'b1;
      else if (step_bwd[a]) pos_nxt[a] = pos_r[a] - 1'b1;
      else pos_nxt[a] = pos_r[a];

      priority if (zero_pos[a]) ph_nxt[a] = '0;
      else if (step_fwd[a] || step_bwd[a]) ph_nxt[a] = ph_step[a];
      else ph_nxt[a] = ph_r[a];

      if (step_fwd[a] || step_bwd[a]) begin
        coils_nxt[a] = (ph_ext < 4'd4) ? (4'b0001 << ph_ext) : '0;
      end else begin
        coils_nxt[a] = coils_r[a];
      end
    end
  end

  // Pack the result as it stands after this tick
  always_comb begin
    logic [tash_pkg::OUT_POS_W-1:0] px;
    logic [tash_pkg::OUT_POS_W-1:0] py;
    logic signed [CMP_W-1:0] ext_x;
    logic signed [CMP_W-1:0] ext_y;
    ext_x = {{16{pos_nxt[0][POS_WIDTH-1]}}, pos_nxt[0]};
    ext_y = {{16{pos_nxt[1][POS_WIDTH-1]}}, pos_nxt[1]};
    px = ext_x[tash_pkg::OUT_POS_W-1:0];
    py = ext_y[tash_pkg::OUT_POS_W-1:0];
    out_data_nxt = {unused_fill, (home_nxt != tash_pkg::HOME_IDLE), py, px, stepped,
                    coils_nxt[1], coils_nxt[0]};
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_side_r <= tash_pkg::AREA_SIDE_RST;
      backoff_x_r <= tash_pkg::BACKOFF_X_RST;
      backoff_y_r <= tash_pkg::BACKOFF_Y_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tash_pkg::REG_AREA_SIDE: area_side_r <= cfg_data[tash_pkg::AREA_W-1:0];
        tash_pkg::REG_BACKOFF_X: backoff_x_r <= cfg_data;
        tash_pkg::REG_BACKOFF_Y: backoff_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance axis state and homing sequence on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_r <= tash_pkg::HOME_IDLE;
      cnt_r  <= '0;
      for (int a = 0; a < 2; a++) begin
        pos_r[a]   <= '0;
        ph_r[a]    <= '0;
        coils_r[a] <= '0;
      end
    end else if (in_accept) begin
      home_r <= home_nxt;
      cnt_r  <= cnt_nxt;
      for (int a = 0; a < 2; a++) begin
        pos_r[a]   <= pos_nxt[a];
        ph_r[a]    <= ph_nxt[a];
        coils_r[a] <= coils_nxt[a];
      end
    end
  end

  // Output register: load on a tick transfer, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### hdl/tash_checker.sv
// Port-level checker for the two-axis stepper homing sequencer, with its bind.
module tash_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [tash_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Every accepted tick produces a result in the next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted tick gave no result");

  // An empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // Coil patterns are wave drive: at most one coil on per axis
  a_wave_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[3:0]) && $onehot0(out_tdata[7:4]))
    else $error("more than one coil driven");

endmodule

bind two_axis_stepper_homing_top tash_checker u_tash_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
